// ----- rtl/core/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH + 1;
  localparam int SUM_WIDTH     = 2 * OPERAND_WIDTH + 2;
  localparam int RES_NUM_WIDTH = 34;
  localparam int RES_DEN_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  typedef struct packed {
    logic [2:0]                      op;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic [OPERAND_WIDTH-1:0]        a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic [OPERAND_WIDTH-1:0]        b_den;
  } in_req_t;

  typedef struct packed {
    logic signed [RES_NUM_WIDTH-1:0] res_num;
    logic [RES_DEN_WIDTH-1:0]        res_den;
    logic                            less;
    logic                            equal;
    logic                            greater;
    logic                            status;
  } out_rsp_t;

endpackage

// ----- rtl/core/rau_mul.sv -----
// Registered unsigned multiplier shared by all cross products.
module rau_mul (
  input  logic                               clk,
  input  logic [rau_pkg::OPERAND_WIDTH-1:0]  mul_a,
  input  logic [rau_pkg::OPERAND_WIDTH-1:0]  mul_b,
  output logic [rau_pkg::PROD_WIDTH-1:0]     prod_r
);
  import rau_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
  end

endmodule

// ----- rtl/core/rau_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module rau_div #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quo_r,
  output logic             done_r
);
  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dsr_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;

  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CW'(WIDTH - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      if (!trial[WIDTH]) begin
        rem_r <= trial[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= shifted[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, gcd datapath and result register.
//
//   Channel   Ports                   Handshake
//   --------  ----------------------  ------------------------------------------
//   request   start, busy, in_data    taken at a clock edge with start high, busy low
//   result    out_valid, out_data     out_valid high for one cycle, always taken
//
// The five cross products go through one registered 16x16 multiplier, the binary gcd runs
// one subtract-and-shift step per cycle, and the two divisions by the gcd run one quotient
// bit per cycle through a shared 33-bit divider. A zero operand denominator, compare only,
// or a zero result denominator skip the gcd and the divisions. Reset is synchronous and
// active low; busy stays high from the accepted request until the result strobe. The
// receiver cannot stall.
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::in_req_t  in_data,
  output logic              out_valid,
  output rau_pkg::out_rsp_t out_data
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(MAG_WIDTH + 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_CALC  = 4'd2;
  localparam logic [3:0] ST_TWO   = 4'd3;
  localparam logic [3:0] ST_GCD   = 4'd4;
  localparam logic [3:0] ST_DIV1S = 4'd5;
  localparam logic [3:0] ST_DIV1W = 4'd6;
  localparam logic [3:0] ST_DIV2S = 4'd7;
  localparam logic [3:0] ST_DIV2W = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]            state_r;
  logic [2:0]            mstep_r;
  in_req_t               req_r;
  logic [W-1:0]          an_mag, bn_mag;
  logic [W-1:0]          mul_a, mul_b;
  logic [PROD_WIDTH-1:0] prod_r;
  logic signed [SUM_WIDTH-1:0] prod_s;
  logic signed [SUM_WIDTH-1:0] p1_r, p2_r, p4_r;
  logic [PROD_WIDTH-1:0] p3_r, p5_r;
  logic signed [SUM_WIDTH-1:0] diff, n_sel;
  logic [PROD_WIDTH-1:0] d_sel;
  logic [MAG_WIDTH-1:0]  x_r, y_r, m_r, d_r, qn_r;
  logic [KW-1:0]         k_r;
  logic                  neg_r;
  logic                  div_go;
  logic [MAG_WIDTH-1:0]  div_dividend, div_divisor, div_quo;
  logic                  div_done;
  logic [MAG_WIDTH-1:0]  sub_xy, sub_yx;
  logic                  zero_den;
  logic [MAG_WIDTH-1:0]  n_mag;

  assign busy     = (state_r != ST_IDLE);
  assign zero_den = (req_r.a_den == '0) || (req_r.b_den == '0);
  assign an_mag   = req_r.a_num[W-1] ? W'(-req_r.a_num) : W'(req_r.a_num);
  assign bn_mag   = req_r.b_num[W-1] ? W'(-req_r.b_num) : W'(req_r.b_num);

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    unique case (mstep_r)
      3'd0:    begin mul_a = an_mag;      mul_b = req_r.b_den; end
      3'd1:    begin mul_a = bn_mag;      mul_b = req_r.a_den; end
      3'd2:    begin mul_a = req_r.a_den; mul_b = req_r.b_den; end
      3'd3:    begin mul_a = an_mag;      mul_b = bn_mag;      end
      default: begin mul_a = req_r.a_den; mul_b = bn_mag;      end
    endcase
  end

  rau_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod_r(prod_r)
  );

  assign prod_s = $signed({2'b00, prod_r});

  // Exact comparison and selection of the unreduced numerator and denominator.
  assign diff = p1_r - p2_r;
  always_comb begin
    unique case (req_r.op)
      OP_ADD:  begin n_sel = p1_r + p2_r; d_sel = p3_r; end
      OP_SUB:  begin n_sel = diff;        d_sel = p3_r; end
      OP_MUL:  begin n_sel = p4_r;        d_sel = p3_r; end
      OP_DIV:  begin n_sel = req_r.b_num[W-1] ? -p1_r : p1_r; d_sel = p5_r; end
      default: begin n_sel = '0;          d_sel = '0;   end
    endcase
  end
  assign n_mag = n_sel[SUM_WIDTH-1] ? MAG_WIDTH'(-n_sel) : MAG_WIDTH'(n_sel);

  assign sub_xy = x_r - y_r;
  assign sub_yx = y_r - x_r;

  assign div_go       = (state_r == ST_DIV1S) || (state_r == ST_DIV2S);
  assign div_dividend = (state_r == ST_DIV1S) ? m_r : d_r;
  assign div_divisor  = y_r << k_r;

  rau_div #(.WIDTH(MAG_WIDTH)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quo_r   (div_quo),
    .done_r  (div_done)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mstep_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_MUL;
            mstep_r <= '0;
          end
        end
        ST_MUL: begin
          mstep_r <= mstep_r + 1'b1;
          if (mstep_r == 3'd5) state_r <= ST_CALC;
        end
        ST_CALC: begin
          if (zero_den || req_r.op > OP_DIV || d_sel == '0) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_TWO;
          end
        end
        ST_TWO: begin
          if (x_r[0] || y_r[0]) state_r <= ST_GCD;
        end
        ST_GCD: begin
          if (x_r == '0) state_r <= ST_DIV1S;
        end
        ST_DIV1S: state_r <= ST_DIV1W;
        ST_DIV1W: if (div_done) state_r <= ST_DIV2S;
        ST_DIV2S: state_r <= ST_DIV2W;
        ST_DIV2W: if (div_done) state_r <= ST_DONE;
        ST_DONE: begin
          out_valid <= 1'b1;
          state_r   <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) req_r <= in_data;
    if (state_r == ST_MUL) begin
      unique case (mstep_r)
        3'd1:    p1_r <= req_r.a_num[W-1] ? -prod_s : prod_s;
        3'd2:    p2_r <= req_r.b_num[W-1] ? -prod_s : prod_s;
        3'd3:    p3_r <= prod_r;
        3'd4:    p4_r <= (req_r.a_num[W-1] ^ req_r.b_num[W-1]) ? -prod_s : prod_s;
        3'd5:    p5_r <= prod_r;
        default: ;
      endcase
    end
    unique case (state_r)
      ST_CALC: begin
        out_data.less    <= !zero_den && diff[SUM_WIDTH-1];
        out_data.equal   <= !zero_den && (diff == '0);
        out_data.greater <= !zero_den && !diff[SUM_WIDTH-1] && (diff != '0);
        out_data.status  <= zero_den || (req_r.op <= OP_DIV && d_sel == '0);
        out_data.res_num <= '0;
        out_data.res_den <= '0;
        neg_r <= n_sel[SUM_WIDTH-1];
        m_r   <= n_mag;
        d_r   <= MAG_WIDTH'(d_sel);
        x_r   <= n_mag;
        y_r   <= MAG_WIDTH'(d_sel);
        k_r   <= '0;
      end
      ST_TWO: begin
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end
      end
      ST_GCD: begin
        priority if (x_r == '0) begin
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= sub_xy >> 1;
        end else begin
          y_r <= sub_yx >> 1;
        end
      end
      ST_DIV1W: if (div_done) qn_r <= div_quo;
      ST_DIV2W: begin
        if (div_done) begin
          out_data.res_num <= neg_r ? -RES_NUM_WIDTH'(qn_r) : RES_NUM_WIDTH'(qn_r);
          out_data.res_den <= RES_DEN_WIDTH'(div_quo);
        end
      end
      default: ;
    endcase
  end

endmodule
